// ===== rtl/anc_pkg.sv =====
// ----------------------------------------------------------------------------
// anc_pkg: shared types and constants of the ARP neighbour cache
// Entry layout, result and operation codes, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package anc_pkg;

    // Neighbour states as stored in an entry.
    localparam logic [2:0] ST_REACHABLE = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_FAILED    = 3'd5;

    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    localparam logic [15:0] TTL_RELOAD_RESET = 16'd300;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_AGE    = 2'd2,
        OP_PACKET = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RES_DONE    = 3'd0,
        RES_FULL    = 3'd1,
        RES_HIT     = 3'd2,
        RES_MISS    = 3'd3,
        RES_IGNORED = 3'd4
    } t_result;

    // What the held item asks for, after the packet opcode is decoded.
    typedef enum logic [1:0] {
        K_ADD,
        K_LOOKUP,
        K_AGE,
        K_IGNORE
    } t_kind;

    typedef enum logic [1:0] {
        SM_LOOKUP,
        SM_ADD,
        SM_VICTIM,
        SM_AGE
    } t_scan_mode;

    typedef enum logic [1:0] {
        WR_HIT,
        WR_APPEND,
        WR_AGE
    } t_wr_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOKUP,
        S_MATCH,
        S_VICTIM,
        S_AGE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [2:0]  st;
        logic [15:0] ttl;
    } t_entry;

    typedef struct packed {
        logic       load_item;
        logic       scan_start;
        logic       scan_en;
        t_scan_mode mode;
        logic       wr_en;
        t_wr_sel    wr_sel;
        logic       used_inc;
        logic       res_load;
        t_result    res_code;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  hit;
        logic  scan_end;
        logic  full;
        logic  dv;
    } t_stat;

endpackage

// ===== rtl/arp_neighbour_cache_unit.sv =====
// ----------------------------------------------------------------------------
// Flow: a lookup, add or age tick scans the stored entries in order before its result
// is loaded; an add into a full table that matches nothing adds a second scan of up to
// TABLE_DEPTH entries for a stale or failed victim. Throughput: one beat at a time; the
// next beat is taken in the cycle after the result is loaded into the output register.
// Reset: synchronous, active low; empties the table, reloads 300, clears both handshakes.
// ----------------------------------------------------------------------------
// arp_neighbour_cache_unit: ARP neighbour cache
// Maps IPv4 addresses to MAC addresses with neighbour state and time-left.
// ----------------------------------------------------------------------------
module arp_neighbour_cache_unit
    import anc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: the time-left reload value.
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_ip_address,
    input  logic [47:0] i_mac_address,
    input  logic [2:0]  i_entry_state,
    input  logic [15:0] i_arp_opcode,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [47:0] o_found_mac,
    output logic        o_send_request,
    output logic [31:0] o_request_ip
);

    // The controller walks each operation through decode, up to two in-order
    // scans of the table and a result stage. The datapath reads one entry per
    // cycle with a registered read, so each scan cycle checks the
    // entry fetched the cycle before. Age ticks write the aged entry back one
    // index behind the read, which never collides with it.
    t_cmd  cmd;
    t_stat stat;

    anc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    // The result sits in an output register, so a finished beat can wait for
    // the consumer while the block already takes the next item.
    anc_dpath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_operation   (i_operation),
        .i_ip_address  (i_ip_address),
        .i_mac_address (i_mac_address),
        .i_entry_state (i_entry_state),
        .i_arp_opcode  (i_arp_opcode),
        .o_status      (o_status),
        .o_found_mac   (o_found_mac),
        .o_send_request(o_send_request),
        .o_request_ip  (o_request_ip)
    );

endmodule

// ===== rtl/anc_ram.sv =====
// ----------------------------------------------------------------------------
// anc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module anc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/anc_dpath.sv =====
// ----------------------------------------------------------------------------
// anc_dpath: datapath of the ARP neighbour cache
// Holds the item, the entry table, the fill count, the scan pipeline,
// the reload register and the result and output registers.
// ----------------------------------------------------------------------------
module anc_dpath
    import anc_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_ip_address,
    input  logic [47:0] i_mac_address,
    input  logic [2:0]  i_entry_state,
    input  logic [15:0] i_arp_opcode,
    output logic [2:0]  o_status,
    output logic [47:0] o_found_mac,
    output logic        o_send_request,
    output logic [31:0] o_request_ip
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Held item.
    t_op         r_op;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [2:0]  r_st;
    logic        r_pkt_ok;

    logic [15:0] r_ttl_reload;
    logic [CW-1:0] r_used;

    // Scan pipeline: next read index, and the index of the data now on the RAM output.
    logic [CW-1:0] r_rd_idx;
    logic          r_dv;
    logic [IW-1:0] r_dv_idx;

    t_result     r_res_code;
    logic [47:0] r_res_mac;
    t_result     r_out_status;
    logic [47:0] r_out_mac;
    logic [31:0] r_out_ip;

    logic          pkt_ok;
    logic [CW-1:0] limit;
    logic          issue;
    logic          rd_en;
    t_entry        q;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [15:0]   ttl_dec;
    logic          match_ip;
    logic          hit;
    t_kind         kind;

    assign pkt_ok = (i_arp_opcode == OPC_REQUEST) || (i_arp_opcode == OPC_REPLY);
    assign limit  = (i_cmd.mode == SM_VICTIM) ? DEPTH_C : r_used;
    assign issue  = r_rd_idx < limit;
    assign rd_en  = i_cmd.scan_en && issue && !i_cmd.scan_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_reload <= TTL_RELOAD_RESET;
            r_used       <= '0;
            r_rd_idx     <= '0;
            r_dv         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ttl_reload <= i_cfg_wdata;
            end
            if (i_cmd.used_inc) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.scan_start || i_cmd.load_item) begin
                r_rd_idx <= '0;
                r_dv     <= 1'b0;
            end else if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
                r_dv     <= 1'b1;
            end else begin
                r_dv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op     <= t_op'(i_operation);
            r_ip     <= i_ip_address;
            r_mac    <= i_mac_address;
            r_pkt_ok <= pkt_ok;
            // The sender of a received packet is stored as reachable when it is added.
            r_st     <= (t_op'(i_operation) == OP_PACKET) ? ST_REACHABLE : i_entry_state;
        end
        if (rd_en) begin
            r_dv_idx <= r_rd_idx[IW-1:0];
        end
        if (i_cmd.res_load) begin
            r_res_code <= i_cmd.res_code;
            r_res_mac  <= (i_cmd.res_code == RES_HIT) ? q.mac : 48'd0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_code;
            r_out_mac    <= r_res_mac;
            r_out_ip     <= (r_res_code == RES_MISS) ? r_ip : 32'd0;
        end
    end

    anc_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(r_rd_idx[IW-1:0]),
        .o_rdata(q)
    );

    assign ttl_dec  = (q.ttl != 16'd0) ? (q.ttl - 16'd1) : 16'd0;
    assign match_ip = (q.ip == r_ip);

    always_comb begin
        wr_addr = r_dv_idx;
        wr_data = '{ip: r_ip, mac: r_mac, st: r_st, ttl: r_ttl_reload};
        unique case (i_cmd.wr_sel)
            WR_HIT: begin
                wr_addr = r_dv_idx;
            end
            WR_APPEND: begin
                wr_addr = r_used[IW-1:0];
            end
            WR_AGE: begin
                wr_addr    = r_dv_idx;
                wr_data    = q;
                wr_data.ttl = ttl_dec;
                if ((ttl_dec == 16'd0) && (q.st == ST_REACHABLE)) begin
                    wr_data.st = ST_STALE;
                end
            end
            default: begin
                wr_addr = r_dv_idx;
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.mode)
            SM_LOOKUP: hit = match_ip && (q.st == ST_REACHABLE);
            SM_ADD:    hit = match_ip;
            SM_VICTIM: hit = (q.st == ST_STALE) || (q.st == ST_FAILED);
            SM_AGE:    hit = 1'b0;
            default:   hit = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_op)
            OP_ADD:    kind = K_ADD;
            OP_LOOKUP: kind = K_LOOKUP;
            OP_AGE:    kind = K_AGE;
            OP_PACKET: kind = r_pkt_ok ? K_ADD : K_IGNORE;
            default:   kind = K_IGNORE;
        endcase
    end

    assign o_stat = '{
        kind:     kind,
        hit:      r_dv && hit,
        scan_end: !r_dv && !issue,
        full:     (r_used == DEPTH_C),
        dv:       r_dv
    };

    assign o_status       = r_out_status;
    assign o_found_mac    = r_out_mac;
    assign o_send_request = (r_out_status == RES_MISS);
    assign o_request_ip   = r_out_ip;

    ap_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= DEPTH_C)
        else $error("fill count beyond table depth");

    ap_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && (i_cmd.wr_sel == WR_APPEND)) |-> (r_used < DEPTH_C))
        else $error("append into a full table");

endmodule

// ===== rtl/anc_ctrl.sv =====
// ----------------------------------------------------------------------------
// anc_ctrl: controller of the ARP neighbour cache
// Sequences decode, table scans, writes and result delivery, and owns the
// input stall and the output valid.
// ----------------------------------------------------------------------------
module anc_ctrl
    import anc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.kind)
                    K_ADD:    n_state = S_MATCH;
                    K_LOOKUP: n_state = S_LOOKUP;
                    K_AGE:    n_state = S_AGE;
                    K_IGNORE: n_state = S_RESP;
                    default:  n_state = S_RESP;
                endcase
            end
            S_LOOKUP: begin
                if (i_stat.hit || i_stat.scan_end) n_state = S_RESP;
            end
            S_MATCH: begin
                priority if (i_stat.hit) n_state = S_RESP;
                else if (i_stat.scan_end) n_state = i_stat.full ? S_VICTIM : S_RESP;
                else n_state = S_MATCH;
            end
            S_VICTIM: begin
                if (i_stat.hit || i_stat.scan_end) n_state = S_RESP;
            end
            S_AGE: begin
                if (i_stat.scan_end) n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.mode     = SM_AGE;
        cmd.wr_sel   = WR_HIT;
        cmd.res_code = RES_DONE;
        unique case (r_state)
            S_IDLE: begin
                cmd.load_item = i_valid;
            end
            S_DECODE: begin
                if (i_stat.kind == K_IGNORE) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_IGNORED;
                end
            end
            S_LOOKUP: begin
                cmd.scan_en = 1'b1;
                cmd.mode    = SM_LOOKUP;
                priority if (i_stat.hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_HIT;
                end else if (i_stat.scan_end) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_MISS;
                end else begin
                    cmd.res_load = 1'b0;
                end
            end
            S_MATCH: begin
                cmd.scan_en = 1'b1;
                cmd.mode    = SM_ADD;
                priority if (i_stat.hit) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_HIT;
                    cmd.res_load = 1'b1;
                end else if (i_stat.scan_end) begin
                    if (i_stat.full) begin
                        cmd.scan_start = 1'b1;
                    end else begin
                        cmd.wr_en    = 1'b1;
                        cmd.wr_sel   = WR_APPEND;
                        cmd.used_inc = 1'b1;
                        cmd.res_load = 1'b1;
                    end
                end else begin
                    cmd.wr_en = 1'b0;
                end
            end
            S_VICTIM: begin
                cmd.scan_en = 1'b1;
                cmd.mode    = SM_VICTIM;
                priority if (i_stat.hit) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_HIT;
                    cmd.res_load = 1'b1;
                end else if (i_stat.scan_end) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = RES_FULL;
                end else begin
                    cmd.wr_en = 1'b0;
                end
            end
            S_AGE: begin
                cmd.scan_en = 1'b1;
                cmd.mode    = SM_AGE;
                cmd.wr_en   = i_stat.dv;
                cmd.wr_sel  = WR_AGE;
                if (i_stat.scan_end) begin
                    cmd.res_load = 1'b1;
                end
            end
            S_RESP: begin
                cmd.out_load = !r_out_valid || !i_stall;
            end
            default: begin
                cmd.load_item = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (cmd.out_load) n_out_valid = 1'b1;
        else if (!i_stall) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !cmd.out_load)
        else $error("output register overwritten while stalled");

    ap_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> ((r_state == S_MATCH) || (r_state == S_VICTIM) || (r_state == S_AGE)))
        else $error("table write outside a scan");

    ap_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule
